FILE: hdl/vtc_pkg.sv
// Shared types, constants and helper functions of the vario tone controller.
package vtc_pkg;

   localparam int RATE_W      = 15;
   localparam int TIME_W      = 32;
   localparam int HZ_W        = 11;
   localparam int LIFT_W      = 9;
   localparam int GAP_W       = 10;
   localparam int COUNT_W     = 3;
   localparam int DIVIDEND_W  = 25;
   localparam int STEP_W      = 5;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 15;

   localparam logic [COUNT_W-1:0] LIFT_CONFIRM = 3'd5;
   localparam logic [COUNT_W-1:0] SINK_CONFIRM = 3'd5;

   localparam logic [LIFT_W-1:0]     LIFT_MAX_CMS   = 9'd499;
   localparam logic [LIFT_W-1:0]     LIFT_RESET_CMS = 9'd10;
   localparam logic [RATE_W-1:0]     SINK_RESET_CMS = 15'h7F6A;
   localparam logic [LIFT_W-1:0]     SPAN_TOP_CMS   = 9'd500;
   localparam logic [GAP_W-1:0]      GAP_SLOPE      = 10'd520;
   localparam logic [GAP_W-1:0]      PITCH_SLOPE    = 10'd700;
   localparam logic [GAP_W-1:0]      GAP_MAX_MS     = 10'd600;
   localparam logic [GAP_W-1:0]      GAP_MIN_MS     = 10'd80;
   localparam logic [GAP_W-1:0]      BEEP_MS        = 10'd80;
   localparam logic [HZ_W-1:0]       PITCH_MIN_HZ   = 11'd800;
   localparam logic [HZ_W-1:0]       PITCH_MAX_HZ   = 11'd1500;
   localparam logic [HZ_W-1:0]       SINK_HZ        = 11'd300;
   localparam logic [STEP_W-1:0]     DIV_LAST_STEP  = 5'(DIVIDEND_W - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_LIFT_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_THRESHOLD = 8'd1;

   typedef enum logic [1:0] {
      EVT_NONE,
      EVT_START,
      EVT_STOP
   } tone_event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic lift_conf;
      logic div_done;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [LIFT_W-1:0]     rem;
      logic [DIVIDEND_W-1:0] quo;
   } div_lane_type;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [LIFT_W-1:0] span);
      logic [LIFT_W:0] shifted;
      logic [LIFT_W:0] trial;
      div_lane_type    res;
      shifted = {lane.rem, lane.quo[DIVIDEND_W-1]};
      trial   = shifted - {1'b0, span};
      if (shifted >= {1'b0, span}) begin
         res.rem = trial[LIFT_W-1:0];
         res.quo = {lane.quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
         res.rem = shifted[LIFT_W-1:0];
         res.quo = {lane.quo[DIVIDEND_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

FILE: hdl/vtc_ctrl.sv
// Sequencing state machine of the vario tone controller.
module vtc_ctrl
   import vtc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = status.lift_conf ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/vtc_dpath.sv
// Datapath of the vario tone controller: counters, tone state, dividers and result register.
module vtc_dpath
   import vtc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output dp_status_type                 status,
   input  logic signed [RATE_W-1:0]      req_climb_rate_cms,
   input  logic [TIME_W-1:0]             req_now_ms,
   input  logic                          csr_valid,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_tone_on,
   output logic [HZ_W-1:0]               rsp_tone_hz,
   output logic [1:0]                    rsp_tone_event
);

   logic [LIFT_W-1:0]        lift_thr_ff, lift_thr_in;
   logic signed [RATE_W-1:0] sink_thr_ff, sink_thr_in;
   logic [COUNT_W-1:0]       lift_count_ff, lift_count_in;
   logic [COUNT_W-1:0]       sink_count_ff, sink_count_in;
   logic                     beeping_ff, beeping_in;
   logic [TIME_W-1:0]        last_edge_ff, last_edge_in;
   logic [HZ_W-1:0]          sounding_hz_ff, sounding_hz_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [LIFT_W-1:0]        span_ff, span_in;
   div_lane_type             gap_lane_ff, gap_lane_in;
   div_lane_type             pitch_lane_ff, pitch_lane_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     tone_on_ff, tone_on_in;
   logic [HZ_W-1:0]          tone_hz_ff, tone_hz_in;
   tone_event_type           tone_event_ff, tone_event_in;

   logic                     lift_seen;
   logic                     sink_seen;
   logic [RATE_W:0]          diff;
   logic [DIVIDEND_W-1:0]    d_ext;
   logic [GAP_W-1:0]         gap;
   logic [HZ_W-1:0]          pitch;
   logic [TIME_W-1:0]        elapsed;
   logic                     lift_conf;
   logic                     sink_conf;

   assign lift_seen = req_climb_rate_cms > $signed({{(RATE_W-LIFT_W){1'b0}}, lift_thr_ff});
   assign sink_seen = req_climb_rate_cms < sink_thr_ff;
   assign diff      = {rate_ff[RATE_W-1], rate_ff} - {{(RATE_W+1-LIFT_W){1'b0}}, lift_thr_ff};
   assign d_ext     = {{(DIVIDEND_W-RATE_W){1'b0}}, diff[RATE_W-1:0]};
   assign lift_conf = lift_count_ff >= LIFT_CONFIRM;
   assign sink_conf = sink_count_ff >= SINK_CONFIRM;
   assign elapsed   = now_ff - last_edge_ff;

   assign gap = (gap_lane_ff.quo > DIVIDEND_W'(GAP_SLOPE)) ? GAP_MIN_MS :
                GAP_MAX_MS - gap_lane_ff.quo[GAP_W-1:0];
   assign pitch = (pitch_lane_ff.quo > DIVIDEND_W'(PITCH_SLOPE)) ? PITCH_MAX_HZ :
                  PITCH_MIN_HZ + pitch_lane_ff.quo[HZ_W-1:0];

   assign status.lift_conf = lift_conf;
   assign status.div_done  = step_ff == DIV_LAST_STEP;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lift_thr_in = lift_thr_ff;
      sink_thr_in = sink_thr_ff;
      if (csr_valid) begin
         if (csr_index == CSR_LIFT_THRESHOLD) begin
            lift_thr_in = (csr_wdata[LIFT_W-1:0] > LIFT_MAX_CMS) ? LIFT_MAX_CMS :
                          csr_wdata[LIFT_W-1:0];
         end else if (csr_index == CSR_SINK_THRESHOLD) begin
            sink_thr_in = $signed(csr_wdata[RATE_W-1:0]);
         end
      end
   end

   always_comb begin
      rate_in       = rate_ff;
      now_in        = now_ff;
      lift_count_in = lift_count_ff;
      sink_count_in = sink_count_ff;
      if (cmd.load) begin
         rate_in = req_climb_rate_cms;
         now_in  = req_now_ms;
         priority if (lift_seen) begin
            if (lift_count_ff < LIFT_CONFIRM) begin
               lift_count_in = lift_count_ff + 3'd1;
            end
            sink_count_in = '0;
         end else if (sink_seen) begin
            if (sink_count_ff < SINK_CONFIRM) begin
               sink_count_in = sink_count_ff + 3'd1;
            end
            lift_count_in = '0;
         end else begin
            lift_count_in = '0;
            sink_count_in = '0;
         end
      end
   end

   always_comb begin
      span_in       = span_ff;
      gap_lane_in   = gap_lane_ff;
      pitch_lane_in = pitch_lane_ff;
      step_in       = step_ff;
      if (cmd.mult) begin
         span_in           = SPAN_TOP_CMS - lift_thr_ff;
         gap_lane_in.rem   = '0;
         gap_lane_in.quo   = d_ext * DIVIDEND_W'(GAP_SLOPE);
         pitch_lane_in.rem = '0;
         pitch_lane_in.quo = d_ext * DIVIDEND_W'(PITCH_SLOPE);
         step_in           = '0;
      end else if (cmd.step) begin
         gap_lane_in   = div_step(gap_lane_ff, span_ff);
         pitch_lane_in = div_step(pitch_lane_ff, span_ff);
         step_in       = step_ff + 5'd1;
      end
   end

   always_comb begin
      beeping_in     = beeping_ff;
      last_edge_in   = last_edge_ff;
      sounding_hz_in = sounding_hz_ff;
      tone_event_in  = tone_event_ff;
      tone_on_in     = tone_on_ff;
      tone_hz_in     = tone_hz_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         tone_event_in = EVT_NONE;
         priority if (lift_conf) begin
            if (!beeping_ff && (elapsed > {{(TIME_W-GAP_W){1'b0}}, gap})) begin
               beeping_in     = 1'b1;
               sounding_hz_in = pitch;
               last_edge_in   = now_ff;
               tone_event_in  = EVT_START;
            end else if (beeping_ff && (elapsed > {{(TIME_W-GAP_W){1'b0}}, BEEP_MS})) begin
               beeping_in     = 1'b0;
               sounding_hz_in = '0;
               last_edge_in   = now_ff;
               tone_event_in  = EVT_STOP;
            end
         end else if (sink_conf) begin
            if (!beeping_ff) begin
               beeping_in     = 1'b1;
               sounding_hz_in = SINK_HZ;
               tone_event_in  = EVT_START;
            end
         end else if (beeping_ff) begin
            beeping_in     = 1'b0;
            sounding_hz_in = '0;
            tone_event_in  = EVT_STOP;
         end
         tone_on_in   = beeping_in;
         tone_hz_in   = beeping_in ? sounding_hz_in : '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_thr_ff    <= LIFT_RESET_CMS;
         sink_thr_ff    <= SINK_RESET_CMS;
         lift_count_ff  <= '0;
         sink_count_ff  <= '0;
         beeping_ff     <= 1'b0;
         last_edge_ff   <= '0;
         sounding_hz_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lift_thr_ff    <= lift_thr_in;
         sink_thr_ff    <= sink_thr_in;
         lift_count_ff  <= lift_count_in;
         sink_count_ff  <= sink_count_in;
         beeping_ff     <= beeping_in;
         last_edge_ff   <= last_edge_in;
         sounding_hz_ff <= sounding_hz_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      now_ff        <= now_in;
      span_ff       <= span_in;
      gap_lane_ff   <= gap_lane_in;
      pitch_lane_ff <= pitch_lane_in;
      step_ff       <= step_in;
      tone_on_ff    <= tone_on_in;
      tone_hz_ff    <= tone_hz_in;
      tone_event_ff <= tone_event_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tone_on    = tone_on_ff;
   assign rsp_tone_hz    = tone_hz_ff;
   assign rsp_tone_event = tone_event_ff;

   a_hz_tracks_beep: assert property (@(posedge clock) disable iff (reset)
      beeping_ff == (sounding_hz_ff != '0))
      else $error("sounding frequency disagrees with beep state");

   a_counts_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((lift_count_ff != '0) && (sink_count_ff != '0)))
      else $error("lift and sink counters both nonzero");

   a_counts_saturate: assert property (@(posedge clock) disable iff (reset)
      (lift_count_ff <= LIFT_CONFIRM) && (sink_count_ff <= SINK_CONFIRM))
      else $error("confirmation counter beyond its limit");

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.mult |=> (span_ff != '0))
      else $error("division span is zero");

endmodule

FILE: hdl/vario_tone_controller_top.sv
// Top level of the vario tone controller.
// A request is accepted only while the controller is idle; it then passes through the multiply,
// divide and finish states, the division only with confirmed lift, and its response may wait on rsp_stall.
// A new request is not taken until the last one is committed; the 25-step serial divider sets the pace.
// Reset is synchronous and active high; it restores the default thresholds,
// clears the lift and sink counters and the beep state, and leaves no response pending.
module vario_tone_controller_top
   import vtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [RATE_W-1:0] req_climb_rate_cms,
   input  logic [TIME_W-1:0]        req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_tone_on,
   output logic [HZ_W-1:0]          rsp_tone_hz,
   output logic [1:0]               rsp_tone_event,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   vtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vtc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_climb_rate_cms (req_climb_rate_cms),
      .req_now_ms         (req_now_ms),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tone_on        (rsp_tone_on),
      .rsp_tone_hz        (rsp_tone_hz),
      .rsp_tone_event     (rsp_tone_event)
   );

endmodule
